### design/brt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brt_pkg
// Shared types, codes and helpers of the block request tracker.
// ----------------------------------------------------------------------------
package brt_pkg;

   localparam int MAX_PIECES = 64;
   localparam int MAX_BLOCKS = 16;
   localparam int NUM_PEERS  = 16;

   localparam int PW = $clog2(MAX_PIECES);
   localparam int BW = $clog2(MAX_BLOCKS);
   localparam int AW = PW + BW;
   localparam int OW = $clog2(NUM_PEERS);
   localparam int CW = 11;
   localparam logic [CW-1:0] CNT_MAX = '1;
   localparam logic [6:0] DONE_MAX = 7'd127;

   // function codes
   localparam logic [2:0] FN_REQUEST = 3'd0;
   localparam logic [2:0] FN_RECEIVE = 3'd1;
   localparam logic [2:0] FN_TICK    = 3'd2;
   localparam logic [2:0] FN_VERIFY  = 3'd3;
   localparam logic [2:0] FN_RESUME  = 3'd4;

   // register indexes
   localparam logic [1:0] CFG_NUM_PIECES = 2'd0;
   localparam logic [1:0] CFG_BLOCKS     = 2'd1;
   localparam logic [1:0] CFG_LAST       = 2'd2;
   localparam logic [1:0] CFG_TIMEOUT    = 2'd3;

   // block states
   localparam logic [1:0] BS_NOTREQ = 2'd0;
   localparam logic [1:0] BS_REQ    = 2'd1;
   localparam logic [1:0] BS_RECV   = 2'd2;

   typedef enum logic [2:0] {
      K_ACK       = 3'd0,
      K_GRANT     = 3'd1,
      K_NONE      = 3'd2,
      K_NEEDV     = 3'd3,
      K_COMPLETED = 3'd4,
      K_RESET     = 3'd5,
      K_RELEASE   = 3'd6,
      K_IGNORED   = 3'd7
   } brt_kind_type;

   typedef enum logic [2:0] {
      SW_INIT,
      SW_REQ,
      SW_CHECK,
      SW_TICK,
      SW_CLEAR
   } brt_sweep_type;

   typedef enum logic [3:0] {
      ST_INIT_GO,
      ST_INIT_WAIT,
      ST_IDLE,
      ST_DECODE,
      ST_SWEEP,
      ST_AFTER,
      ST_SWEEP2,
      ST_PEER,
      ST_EMIT
   } brt_state_type;

   typedef struct packed {
      logic          cap;
      logic          sw_start;
      brt_sweep_type sw_mode;
      logic          recv_wr;
      logic          set_done;
      logic          cnt_clr;
      logic          load;
      brt_kind_type  kind;
      logic          last;
      logic          ptr_next;
   } brt_cmd_type;

   typedef struct packed {
      logic [2:0] func;
      logic       ign;
      logic       done_p;
      logic       ok;
      logic       busy;
      logic       found;
      logic       all_recv;
      logic       out_free;
      logic       rel_any;
      logic       rel_cur;
      logic       rel_above;
   } brt_status_type;

   function automatic logic [6:0] eff_pieces(input logic [6:0] np);
      logic [6:0] n;
      n = np;
      if (n == 7'd0) n = 7'd1;
      if (n > 7'(MAX_PIECES)) n = 7'(MAX_PIECES);
      return n;
   endfunction

   function automatic logic [4:0] blocks_in(input logic [PW-1:0] q, input logic [6:0] eff,
                                            input logic [4:0] bpp, input logic [4:0] lpb);
      logic [4:0] n;
      n = ((7'(q) + 7'd1) < eff) ? bpp : lpb;
      if (n == 5'd0) n = 5'd1;
      if (n > 5'(MAX_BLOCKS)) n = 5'(MAX_BLOCKS);
      return n;
   endfunction

endpackage
`default_nettype wire

### design/brt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brt_ctrl
// Sequencer: decodes an item, runs table sweeps and issues the result words.
// ----------------------------------------------------------------------------
module brt_ctrl
   import brt_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  brt_status_type      status,
   output brt_cmd_type         cmd
);

   brt_state_type state_ff, state_in;
   brt_kind_type  kind_ff, kind_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT_GO;
      end else begin
         state_ff <= state_in;
      end
      kind_ff <= kind_in;
   end

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      cmd          = '0;
      cmd.sw_mode  = SW_INIT;
      cmd.kind     = kind_ff;
      req_ready    = 1'b0;
      unique case (state_ff)
         ST_INIT_GO: begin
            cmd.sw_start = 1'b1;
            cmd.sw_mode  = SW_INIT;
            state_in     = ST_INIT_WAIT;
         end
         ST_INIT_WAIT: begin
            if (!status.busy) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.cap  = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            kind_in  = K_IGNORED;
            state_in = ST_EMIT;
            if (!status.ign) begin
               priority case (status.func)
                  FN_REQUEST: begin
                     cmd.sw_start = 1'b1;
                     cmd.sw_mode  = SW_REQ;
                     state_in     = ST_SWEEP;
                  end
                  FN_RECEIVE: begin
                     cmd.recv_wr  = 1'b1;
                     cmd.sw_start = 1'b1;
                     cmd.sw_mode  = SW_CHECK;
                     state_in     = ST_SWEEP;
                  end
                  FN_TICK: begin
                     cmd.cnt_clr  = 1'b1;
                     cmd.sw_start = 1'b1;
                     cmd.sw_mode  = SW_TICK;
                     state_in     = ST_SWEEP;
                  end
                  FN_VERIFY: begin
                     cmd.sw_start = 1'b1;
                     cmd.sw_mode  = SW_CHECK;
                     state_in     = ST_SWEEP;
                  end
                  FN_RESUME: begin
                     if (status.done_p) begin
                        kind_in = K_ACK;
                     end else begin
                        cmd.set_done = 1'b1;
                        cmd.sw_start = 1'b1;
                        cmd.sw_mode  = SW_CLEAR;
                        state_in     = ST_SWEEP;
                     end
                  end
                  default: state_in = ST_EMIT;
               endcase
            end
         end
         ST_SWEEP: begin
            if (!status.busy) state_in = ST_AFTER;
         end
         ST_AFTER: begin
            state_in = ST_EMIT;
            priority case (status.func)
               FN_REQUEST: kind_in = status.found ? K_GRANT : K_NONE;
               FN_RECEIVE: kind_in = status.all_recv ? K_NEEDV : K_ACK;
               FN_TICK:    state_in = ST_PEER;
               FN_VERIFY: begin
                  if (!status.all_recv) begin
                     kind_in = K_IGNORED;
                  end else begin
                     cmd.set_done = status.ok;
                     cmd.sw_start = 1'b1;
                     cmd.sw_mode  = SW_CLEAR;
                     kind_in      = status.ok ? K_COMPLETED : K_RESET;
                     state_in     = ST_SWEEP2;
                  end
               end
               default: kind_in = K_COMPLETED;
            endcase
         end
         ST_SWEEP2: begin
            if (!status.busy) state_in = ST_EMIT;
         end
         ST_PEER: begin
            if (!status.rel_any) begin
               kind_in  = K_ACK;
               state_in = ST_EMIT;
            end else if (!status.rel_cur) begin
               cmd.ptr_next = 1'b1;
            end else if (status.out_free) begin
               cmd.load     = 1'b1;
               cmd.kind     = K_RELEASE;
               cmd.last     = !status.rel_above;
               cmd.ptr_next = 1'b1;
               if (!status.rel_above) state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.load = 1'b1;
               cmd.kind = kind_ff;
               cmd.last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

### design/brt_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brt_datapath
// Block table memory, sweep engine, piece flags, counters and result register.
// ----------------------------------------------------------------------------
module brt_datapath
   import brt_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  brt_cmd_type         cmd,
   output brt_status_type      status,
   input  wire logic [2:0]     req_func,
   input  wire logic [5:0]     req_piece_index,
   input  wire logic [3:0]     req_block_index,
   input  wire logic [63:0]    req_peer_pieces,
   input  wire logic [3:0]     req_peer_id,
   input  wire logic           req_hash_ok,
   input  wire logic           csr_valid,
   input  wire logic [1:0]     csr_index,
   input  wire logic [6:0]     csr_wdata,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   output logic [2:0]          rsp_kind,
   output logic [5:0]          rsp_out_piece,
   output logic [3:0]          rsp_out_block,
   output logic [3:0]          rsp_out_peer,
   output logic [10:0]         rsp_released_count,
   output logic [6:0]          rsp_completed_total,
   output logic                rsp_last
);

   // item and configuration
   logic [2:0]            func_ff;
   logic [PW-1:0]         piece_ff;
   logic [BW-1:0]         blk_ff;
   logic [MAX_PIECES-1:0] held_ff;
   logic [OW-1:0]         peer_ff;
   logic                  ok_ff;
   logic [6:0]            np_ff;
   logic [4:0]            bpp_ff, lpb_ff;
   logic [2:0]            tmo_ff;

   logic [6:0]            eff;
   logic [4:0]            nb_p;

   always_ff @(posedge clock) begin
      if (cmd.cap) begin
         func_ff  <= req_func;
         piece_ff <= req_piece_index;
         blk_ff   <= req_block_index;
         held_ff  <= req_peer_pieces;
         peer_ff  <= req_peer_id;
         ok_ff    <= req_hash_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         np_ff  <= 7'(MAX_PIECES);
         bpp_ff <= 5'(MAX_BLOCKS);
         lpb_ff <= 5'(MAX_BLOCKS);
         tmo_ff <= 3'd3;
      end else if (csr_valid) begin
         unique case (csr_index)
            CFG_NUM_PIECES: np_ff  <= csr_wdata;
            CFG_BLOCKS:     bpp_ff <= csr_wdata[4:0];
            CFG_LAST:       lpb_ff <= csr_wdata[4:0];
            CFG_TIMEOUT:    tmo_ff <= csr_wdata[2:0];
            default:        tmo_ff <= tmo_ff;
         endcase
      end
   end

   assign eff  = eff_pieces(np_ff);
   assign nb_p = blocks_in(piece_ff, eff, bpp_ff, lpb_ff);

   // piece flags
   logic [MAX_PIECES-1:0] done_ff;
   logic [6:0]            done_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff     <= '0;
         done_cnt_ff <= '0;
      end else if (cmd.set_done) begin
         done_ff[piece_ff] <= 1'b1;
         if (done_cnt_ff != DONE_MAX) done_cnt_ff <= done_cnt_ff + 7'd1;
      end
   end

   // sweep engine
   brt_sweep_type   mode_ff;
   logic            sw_active_ff, sw_active_in;
   logic [AW-1:0]   sw_addr_ff, sw_addr_in;
   logic            rd_v_ff;
   logic [AW-1:0]   rd_addr_ff;
   logic [8:0]      mem_q_ff;
   logic [8:0]      blk_mem [MAX_PIECES*MAX_BLOCKS];
   logic            found_ff, found_in;
   logic [AW-1:0]   found_addr_ff;
   logic            all_ff, all_in;

   logic            read_mode, at_end, issue, stop;
   logic [PW-1:0]   rq;
   logic [BW-1:0]   rj;
   logic [4:0]      nb_q;
   logic            in_range;
   logic [1:0]      e_st;
   logic [2:0]      e_age, age1;
   logic [OW-1:0]   e_own;
   logic            hit_req, hit_tick, expire;
   logic            mem_we;
   logic [AW-1:0]   mem_wa;
   logic [8:0]      mem_wd;

   assign read_mode = (mode_ff == SW_REQ) || (mode_ff == SW_CHECK) || (mode_ff == SW_TICK);
   assign at_end    = ((mode_ff == SW_CHECK) || (mode_ff == SW_CLEAR)) ?
                      (sw_addr_ff[BW-1:0] == '1) : (sw_addr_ff == '1);

   assign rq       = rd_addr_ff[AW-1:BW];
   assign rj       = rd_addr_ff[BW-1:0];
   assign nb_q     = blocks_in(rq, eff, bpp_ff, lpb_ff);
   assign in_range = (7'(rq) < eff) && (5'(rj) < nb_q) && !done_ff[rq];
   assign e_st     = mem_q_ff[8:7];
   assign e_age    = mem_q_ff[6:4];
   assign e_own    = mem_q_ff[OW-1:0];
   assign age1     = (e_age == 3'd7) ? e_age : e_age + 3'd1;
   assign expire   = age1 >= tmo_ff;

   assign hit_req  = rd_v_ff && (mode_ff == SW_REQ) && in_range && held_ff[rq] &&
                     (e_st == BS_NOTREQ);
   assign hit_tick = rd_v_ff && (mode_ff == SW_TICK) && in_range && (e_st == BS_REQ);
   assign stop     = hit_req;
   assign issue    = sw_active_ff && read_mode && !stop;

   always_comb begin
      sw_active_in = sw_active_ff;
      sw_addr_in   = sw_addr_ff;
      found_in     = found_ff;
      all_in       = all_ff;
      if (cmd.sw_start) begin
         sw_active_in = 1'b1;
         sw_addr_in   = ((cmd.sw_mode == SW_CHECK) || (cmd.sw_mode == SW_CLEAR)) ?
                        {piece_ff, {BW{1'b0}}} : '0;
         found_in     = 1'b0;
         all_in       = 1'b1;
      end else begin
         if (sw_active_ff) begin
            sw_addr_in = sw_addr_ff + AW'(1);
            if (at_end) sw_active_in = 1'b0;
         end
         if (stop) begin
            sw_active_in = 1'b0;
            found_in     = 1'b1;
         end
         if (rd_v_ff && (mode_ff == SW_CHECK) && (5'(rj) < nb_p) && (e_st != BS_RECV))
            all_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sw_active_ff <= 1'b0;
         rd_v_ff      <= 1'b0;
      end else begin
         sw_active_ff <= sw_active_in;
         rd_v_ff      <= issue;
      end
      if (cmd.sw_start) mode_ff <= cmd.sw_mode;
      sw_addr_ff <= sw_addr_in;
      rd_addr_ff <= sw_addr_ff;
      found_ff   <= found_in;
      all_ff     <= all_in;
      if (hit_req) found_addr_ff <= rd_addr_ff;
   end

   // single write port
   always_comb begin
      mem_we = 1'b0;
      mem_wa = sw_addr_ff;
      mem_wd = '0;
      if (sw_active_ff && ((mode_ff == SW_INIT) || (mode_ff == SW_CLEAR))) begin
         mem_we = 1'b1;
      end else if (cmd.recv_wr) begin
         mem_we = 1'b1;
         mem_wa = {piece_ff, blk_ff};
         mem_wd = {BS_RECV, 7'd0};
      end else if (hit_req) begin
         mem_we = 1'b1;
         mem_wa = rd_addr_ff;
         mem_wd = {BS_REQ, 3'd0, peer_ff};
      end else if (hit_tick) begin
         mem_we = 1'b1;
         mem_wa = rd_addr_ff;
         mem_wd = expire ? 9'd0 : {BS_REQ, age1, e_own};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) blk_mem[mem_wa] <= mem_wd;
      mem_q_ff <= blk_mem[sw_addr_ff];
   end

   // per-peer release counts
   logic [CW-1:0]        cnt_ff [NUM_PEERS];
   logic [OW-1:0]        ptr_ff;
   logic [OW-1:0]        cnt_idx;
   logic [CW-1:0]        cnt_cur;
   logic [NUM_PEERS-1:0] nz;
   logic [NUM_PEERS-1:0] nz_above;

   assign cnt_idx  = rd_v_ff ? e_own : ptr_ff;
   assign cnt_cur  = cnt_ff[cnt_idx];
   assign nz_above = (nz >> ptr_ff) >> 1;

   always_comb begin
      for (int i = 0; i < NUM_PEERS; i++) nz[i] = (cnt_ff[i] != '0);
   end

   always_ff @(posedge clock) begin
      if (cmd.cnt_clr) begin
         for (int i = 0; i < NUM_PEERS; i++) cnt_ff[i] <= '0;
         ptr_ff <= '0;
      end else begin
         if (hit_tick && expire && (cnt_cur != CNT_MAX)) cnt_ff[cnt_idx] <= cnt_cur + CW'(1);
         if (cmd.ptr_next) ptr_ff <= ptr_ff + OW'(1);
      end
   end

   // result word
   logic       rsp_valid_ff;
   logic [2:0] kind_ff;
   logic [5:0] opiece_ff;
   logic [3:0] oblock_ff, opeer_ff;
   logic [10:0] ocnt_ff;
   logic [6:0] ototal_ff;
   logic       olast_ff;
   logic       use_piece;

   assign use_piece = (cmd.kind == K_NEEDV) || (cmd.kind == K_COMPLETED) ||
                      (cmd.kind == K_RESET) || ((cmd.kind == K_ACK) && (func_ff != FN_TICK));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.load) begin
         kind_ff   <= cmd.kind;
         opiece_ff <= (cmd.kind == K_GRANT) ? found_addr_ff[AW-1:BW] :
                      use_piece ? piece_ff : '0;
         oblock_ff <= (cmd.kind == K_GRANT) ? found_addr_ff[BW-1:0] : '0;
         opeer_ff  <= (cmd.kind == K_RELEASE) ? ptr_ff : '0;
         ocnt_ff   <= (cmd.kind == K_RELEASE) ? cnt_cur : '0;
         ototal_ff <= done_cnt_ff;
         olast_ff  <= cmd.last;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_kind            = kind_ff;
   assign rsp_out_piece       = opiece_ff;
   assign rsp_out_block       = oblock_ff;
   assign rsp_out_peer        = opeer_ff;
   assign rsp_released_count  = ocnt_ff;
   assign rsp_completed_total = ototal_ff;
   assign rsp_last            = olast_ff;

   // status towards the sequencer
   always_comb begin
      status.func      = func_ff;
      status.done_p    = done_ff[piece_ff];
      status.ok        = ok_ff;
      status.busy      = sw_active_ff || rd_v_ff;
      status.found     = found_ff;
      status.all_recv  = all_ff;
      status.out_free  = !rsp_valid_ff || rsp_ready;
      status.rel_any   = |nz;
      status.rel_cur   = nz[ptr_ff];
      status.rel_above = |nz_above;
      priority case (func_ff)
         FN_REQUEST: status.ign = ({1'b0, peer_ff} >= (OW+1)'(NUM_PEERS));
         FN_RECEIVE: status.ign = (7'(piece_ff) >= eff) || done_ff[piece_ff] ||
                                  (5'(blk_ff) >= nb_p);
         FN_TICK:    status.ign = 1'b0;
         FN_VERIFY:  status.ign = (7'(piece_ff) >= eff) || done_ff[piece_ff];
         FN_RESUME:  status.ign = (7'(piece_ff) >= eff);
         default:    status.ign = 1'b1;
      endcase
   end

endmodule
`default_nettype wire

### design/block_request_tracker_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Sweeps: request and tick walk the block table one entry a cycle through the block memory
//   port; a tick then walks the peer counters in order up to the last releasing one,
//   waiting at each releasing peer until the result register is free.
// Throughput: one word at a time; req_ready is high only while the sequencer is idle.
// Reset: synchronous; a clearing pass sweeps the block table before the first word
//   is taken; configuration returns to 64 / 16 / 16 / 3.
// ----------------------------------------------------------------------------
// block_request_tracker_top
// Per-block request tracker with grant search, timeout sweep and piece verify.
// ----------------------------------------------------------------------------
module block_request_tracker_top
   import brt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_func,
   input  wire logic [5:0]  req_piece_index,
   input  wire logic [3:0]  req_block_index,
   input  wire logic [63:0] req_peer_pieces,
   input  wire logic [3:0]  req_peer_id,
   input  wire logic        req_hash_ok,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_kind,
   output logic [5:0]       rsp_out_piece,
   output logic [3:0]       rsp_out_block,
   output logic [3:0]       rsp_out_peer,
   output logic [10:0]      rsp_released_count,
   output logic [6:0]       rsp_completed_total,
   output logic             rsp_last,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [6:0]  csr_wdata
);

   brt_cmd_type    cmd;
   brt_status_type status;

   assign csr_ready = 1'b1;

   brt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   brt_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_func            (req_func),
      .req_piece_index     (req_piece_index),
      .req_block_index     (req_block_index),
      .req_peer_pieces     (req_peer_pieces),
      .req_peer_id         (req_peer_id),
      .req_hash_ok         (req_hash_ok),
      .csr_valid           (csr_valid),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_kind            (rsp_kind),
      .rsp_out_piece       (rsp_out_piece),
      .rsp_out_block       (rsp_out_block),
      .rsp_out_peer        (rsp_out_peer),
      .rsp_released_count  (rsp_released_count),
      .rsp_completed_total (rsp_completed_total),
      .rsp_last            (rsp_last)
   );

endmodule
`default_nettype wire

### verif/tb_block_request_tracker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_block_request_tracker_top
// Drives request, receive, tick, verify and resume words into the block
// request tracker under several table sizes and timeouts, and checks every
// result word against a behavioural copy of the block table kept here.
// ----------------------------------------------------------------------------
module tb_block_request_tracker_top;
   import brt_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;

   typedef struct {
      brt_kind_type kind;
      logic [5:0]   piece;
      logic [3:0]   blk;
      logic [3:0]   peer;
      logic [10:0]  cnt;
      logic [6:0]   total;
      logic         last;
   } rsp_word_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_func;
   logic [5:0]  req_piece_index;
   logic [3:0]  req_block_index;
   logic [63:0] req_peer_pieces;
   logic [3:0]  req_peer_id;
   logic        req_hash_ok;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_kind;
   logic [5:0]  rsp_out_piece;
   logic [3:0]  rsp_out_block;
   logic [3:0]  rsp_out_peer;
   logic [10:0] rsp_released_count;
   logic [6:0]  rsp_completed_total;
   logic        rsp_last;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [6:0]  csr_wdata;

   block_request_tracker_top dut (.*);

   // tracker copy
   logic [1:0] blk_state [MAX_PIECES*MAX_BLOCKS];
   logic [2:0] blk_age   [MAX_PIECES*MAX_BLOCKS];
   logic [3:0] blk_owner [MAX_PIECES*MAX_BLOCKS];
   logic       piece_fin [MAX_PIECES];
   int         fin_count;
   int         cfg_np, cfg_bpp, cfg_lpb, cfg_tmo;

   rsp_word_type pending_rsp [$];
   int           mismatches;
   int           cycles;
   int           send_idle;
   int           recv_idle;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_block_request_tracker_top NOT OK");
         $finish;
      end
   end

   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= recv_idle);

   function automatic int live_pieces();
      int n;
      n = cfg_np;
      if (n == 0) n = 1;
      if (n > MAX_PIECES) n = MAX_PIECES;
      return n;
   endfunction

   function automatic int piece_blocks(int q);
      int n;
      n = (q + 1 < live_pieces()) ? cfg_bpp : cfg_lpb;
      if (n == 0) n = 1;
      if (n > MAX_BLOCKS) n = MAX_BLOCKS;
      return n;
   endfunction

   function automatic void wipe_piece(int q);
      for (int j = 0; j < MAX_BLOCKS; j++) begin
         blk_state[q*MAX_BLOCKS+j] = BS_NOTREQ;
         blk_age[q*MAX_BLOCKS+j]   = '0;
         blk_owner[q*MAX_BLOCKS+j] = '0;
      end
   endfunction

   function automatic bit piece_full(int q);
      bit all;
      all = 1'b1;
      for (int j = 0; j < piece_blocks(q); j++)
         if (blk_state[q*MAX_BLOCKS+j] != BS_RECV) all = 1'b0;
      return all;
   endfunction

   function automatic void finish_piece(int q);
      piece_fin[q] = 1'b1;
      wipe_piece(q);
      if (fin_count < 127) fin_count++;
   endfunction

   function automatic rsp_word_type mk(brt_kind_type k, int p, int b, int o, int c);
      rsp_word_type r;
      r.kind  = k;
      r.piece = 6'(p);
      r.blk   = 4'(b);
      r.peer  = 4'(o);
      r.cnt   = 11'(c);
      r.total = '0;
      r.last  = 1'b0;
      return r;
   endfunction

   // works out the result words of one accepted word and updates the table
   function automatic void track_word(logic [2:0] f, logic [5:0] p, logic [3:0] b,
                                      logic [63:0] held, logic [3:0] id, logic ok);
      rsp_word_type out [$];
      int           np;
      int           k;
      int           age;
      int           rel [NUM_PEERS];
      bit           granted;
      np = live_pieces();
      granted = 1'b0;
      case (f)
         FN_REQUEST: begin
            for (int q = 0; q < np && !granted; q++) begin
               if (piece_fin[q] || !held[q]) continue;
               for (int j = 0; j < piece_blocks(q); j++) begin
                  k = q*MAX_BLOCKS + j;
                  if (blk_state[k] == BS_NOTREQ) begin
                     blk_state[k] = BS_REQ;
                     blk_owner[k] = id;
                     blk_age[k]   = '0;
                     out = {out, mk(K_GRANT, q, j, 0, 0)};
                     granted = 1'b1;
                     break;
                  end
               end
            end
            if (!granted) out = {out, mk(K_NONE, 0, 0, 0, 0)};
         end
         FN_RECEIVE: begin
            if (p >= np || piece_fin[p] || b >= piece_blocks(p)) begin
               out = {out, mk(K_IGNORED, 0, 0, 0, 0)};
            end else begin
               k = p*MAX_BLOCKS + b;
               blk_state[k] = BS_RECV;
               blk_age[k]   = '0;
               blk_owner[k] = '0;
               out = {out, mk(piece_full(p) ? K_NEEDV : K_ACK, p, 0, 0, 0)};
            end
         end
         FN_TICK: begin
            foreach (rel[i]) rel[i] = 0;
            for (int q = 0; q < np; q++) begin
               if (piece_fin[q]) continue;
               for (int j = 0; j < piece_blocks(q); j++) begin
                  k = q*MAX_BLOCKS + j;
                  if (blk_state[k] != BS_REQ) continue;
                  age = blk_age[k];
                  if (age < 7) age++;
                  if (age >= cfg_tmo) begin
                     if (rel[blk_owner[k]] < 2047) rel[blk_owner[k]]++;
                     blk_state[k] = BS_NOTREQ;
                     blk_age[k]   = '0;
                     blk_owner[k] = '0;
                  end else begin
                     blk_age[k] = 3'(age);
                  end
               end
            end
            for (int i = 0; i < NUM_PEERS; i++)
               if (rel[i] != 0) out = {out, mk(K_RELEASE, 0, 0, i, rel[i])};
            if (out.size() == 0) out = {out, mk(K_ACK, 0, 0, 0, 0)};
         end
         FN_VERIFY: begin
            if (p >= np || piece_fin[p] || !piece_full(p)) begin
               out = {out, mk(K_IGNORED, 0, 0, 0, 0)};
            end else if (ok) begin
               finish_piece(p);
               out = {out, mk(K_COMPLETED, p, 0, 0, 0)};
            end else begin
               wipe_piece(p);
               out = {out, mk(K_RESET, p, 0, 0, 0)};
            end
         end
         FN_RESUME: begin
            if (p >= np) begin
               out = {out, mk(K_IGNORED, 0, 0, 0, 0)};
            end else if (piece_fin[p]) begin
               out = {out, mk(K_ACK, p, 0, 0, 0)};
            end else begin
               finish_piece(p);
               out = {out, mk(K_COMPLETED, p, 0, 0, 0)};
            end
         end
         default: out = {out, mk(K_IGNORED, 0, 0, 0, 0)};
      endcase
      foreach (out[i]) begin
         out[i].total = 7'(fin_count);
         out[i].last  = (i == out.size() - 1);
         pending_rsp = {pending_rsp, out[i]};
      end
   endfunction

   always @(posedge clock) begin
      rsp_word_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result word kind %0d piece %0d", rsp_kind, rsp_out_piece);
         end else begin
            w = pending_rsp.pop_front();
            if (rsp_kind !== w.kind || rsp_out_piece !== w.piece || rsp_out_block !== w.blk
                || rsp_out_peer !== w.peer || rsp_released_count !== w.cnt
                || rsp_completed_total !== w.total || rsp_last !== w.last) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: exp k%0d p%0d b%0d o%0d c%0d t%0d l%0d",
                           w.kind, w.piece, w.blk, w.peer, w.cnt, w.total, w.last);
                  $display("          got k%0d p%0d b%0d o%0d c%0d t%0d l%0d",
                           rsp_kind, rsp_out_piece, rsp_out_block, rsp_out_peer,
                           rsp_released_count, rsp_completed_total, rsp_last);
               end
            end
         end
      end
   end

   task automatic send_word(logic [2:0] f, logic [5:0] p, logic [3:0] b,
                            logic [63:0] held, logic [3:0] id, logic ok);
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
      req_valid       <= 1'b1;
      req_func        <= f;
      req_piece_index <= p;
      req_block_index <= b;
      req_peer_pieces <= held;
      req_peer_id     <= id;
      req_hash_ok     <= ok;
      track_word(f, p, b, held, id, ok);
      do @(posedge clock); while (!req_ready);
   endtask

   // stop sending and wait for every outstanding result word
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [6:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CFG_NUM_PIECES: cfg_np  = v;
         CFG_BLOCKS:     cfg_bpp = v & 7'd31;
         CFG_LAST:       cfg_lpb = v & 7'd31;
         default:        cfg_tmo = v & 7'd7;
      endcase
   endtask

   task automatic set_cfg(logic [6:0] np, logic [6:0] bpp, logic [6:0] lpb, logic [6:0] tmo);
      drain();
      csr_write(CFG_NUM_PIECES, np);
      csr_write(CFG_BLOCKS, bpp);
      csr_write(CFG_LAST, lpb);
      csr_write(CFG_TIMEOUT, tmo);
      csr_valid <= 1'b0;
   endtask

   // mostly plausible traffic for the current sizes, some raw noise
   task automatic rand_word();
      int          sel;
      int          p;
      logic [63:0] held;
      sel  = $urandom_range(99);
      p    = $urandom_range(live_pieces() - 1);
      held = {$urandom, $urandom};
      if ($urandom_range(1)) held = '1;
      if (sel < 30)
         send_word(FN_REQUEST, 6'($urandom), 4'($urandom), held, 4'($urandom), 1'($urandom));
      else if (sel < 58)
         send_word(FN_RECEIVE, 6'(p), 4'($urandom_range(piece_blocks(p) - 1)), held,
                   4'($urandom), 1'($urandom));
      else if (sel < 72)
         send_word(FN_TICK, 6'($urandom), 4'($urandom), held, 4'($urandom), 1'($urandom));
      else if (sel < 85)
         send_word(FN_VERIFY, 6'(p), 4'($urandom), held, 4'($urandom),
                   ($urandom_range(3) != 0));
      else if (sel < 89)
         send_word(FN_RESUME, 6'(p), 4'($urandom), held, 4'($urandom), 1'($urandom));
      else
         send_word(3'($urandom), 6'($urandom), 4'($urandom), {$urandom, $urandom},
                   4'($urandom), 1'($urandom));
   endtask

   task automatic test_directed();
      send_word(FN_REQUEST, '0, '0, '0, 4'd0, 1'b0);
      send_word(FN_REQUEST, '0, '0, 64'h8000_0000_0000_0000, 4'd15, 1'b0);
      send_word(FN_TICK, '1, '1, '1, '1, 1'b1);
      set_cfg(7'd2, 7'd2, 7'd1, 7'd1);
      send_word(FN_REQUEST, '0, '0, '1, 4'd0, 1'b0);
      send_word(FN_REQUEST, '0, '0, '1, 4'd15, 1'b1);
      send_word(FN_REQUEST, '0, '0, '1, 4'd7, 1'b0);
      send_word(FN_REQUEST, '0, '0, '1, 4'd8, 1'b0);
      send_word(FN_TICK, '0, '0, '0, '0, 1'b0);
      send_word(FN_TICK, '0, '0, '0, '0, 1'b0);
      send_word(FN_RECEIVE, 6'd0, 4'd0, '0, '0, 1'b0);
      send_word(FN_VERIFY, 6'd0, '0, '0, '0, 1'b1);
      send_word(FN_RECEIVE, 6'd0, 4'd0, '0, '0, 1'b0);
      send_word(FN_RECEIVE, 6'd0, 4'd1, '0, '0, 1'b0);
      send_word(FN_VERIFY, 6'd0, '0, '0, '0, 1'b0);
      send_word(FN_RECEIVE, 6'd0, 4'd0, '0, '0, 1'b0);
      send_word(FN_RECEIVE, 6'd0, 4'd1, '0, '0, 1'b0);
      send_word(FN_VERIFY, 6'd0, '1, '0, '0, 1'b1);
      send_word(FN_RECEIVE, 6'd0, 4'd0, '0, '0, 1'b0);
      send_word(FN_VERIFY, 6'd0, '0, '0, '0, 1'b1);
      send_word(FN_RESUME, 6'd0, '0, '0, '0, 1'b0);
      send_word(FN_RECEIVE, 6'd1, 4'd15, '0, '0, 1'b0);
      send_word(FN_RESUME, 6'd1, '0, '0, '0, 1'b0);
      send_word(FN_RESUME, 6'd63, '0, '0, '0, 1'b0);
      send_word(3'd5, '1, '1, '1, '1, 1'b1);
      send_word(3'd6, '0, '0, '0, '0, 1'b0);
      send_word(3'd7, '1, '1, '1, '1, 1'b1);
   endtask

   task automatic test_random(int n);
      repeat (n) rand_word();
   endtask

   initial begin
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_func        <= '0;
      req_piece_index <= '0;
      req_block_index <= '0;
      req_peer_pieces <= '0;
      req_peer_id     <= '0;
      req_hash_ok     <= 1'b0;
      csr_valid       <= 1'b0;
      csr_index       <= '0;
      csr_wdata       <= '0;
      send_idle  = 0;
      recv_idle  = 0;
      fin_count  = 0;
      cfg_np = 64; cfg_bpp = 16; cfg_lpb = 16; cfg_tmo = 3;
      foreach (piece_fin[q]) begin
         piece_fin[q] = 1'b0;
         wipe_piece(q);
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_directed();

      send_idle = 17; recv_idle = 79;
      set_cfg(7'd4, 7'd2, 7'd3, 7'd2);
      test_random(15);
      set_cfg(7'd0, 7'd0, 7'd0, 7'd0);
      test_random(10);

      send_idle = 79; recv_idle = 17;
      set_cfg(7'd127, 7'd31, 7'd31, 7'd7);
      test_random(8);
      set_cfg(7'd64, 7'd1, 7'd16, 7'd5);
      test_random(10);

      send_idle = 0; recv_idle = 0;
      set_cfg(7'd1, 7'd16, 7'd16, 7'd1);
      test_random(10);
      set_cfg(7'($urandom_range(2, 8)), 7'($urandom_range(1, 4)), 7'($urandom_range(1, 4)),
              7'($urandom_range(1, 7)));
      test_random(20);

      drain();
      repeat (1100) @(posedge clock);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("tb_block_request_tracker_top OK");
      end else begin
         $display("tb_block_request_tracker_top NOT OK");
      end
      $finish;
   end

endmodule
